[rtl/core/i2csbc_pkg.sv]
`default_nettype none

package i2csbc_pkg;

    // Event codes carried in the input tuser field.
    typedef enum logic [2:0] {
        ACT_START = 3'd0,
        ACT_SHIFT = 3'd1,
        ACT_PUSH  = 3'd2,
        ACT_POP   = 3'd3,
        ACT_FLUSH = 3'd4
    } action_t;

    // Bus mode codes reported with every result.
    localparam logic [2:0] MODE_WAIT_START = 3'd0;
    localparam logic [2:0] MODE_DRIVE_ACK  = 3'd1;
    localparam logic [2:0] MODE_SAMPLE_ACK = 3'd2;
    localparam logic [2:0] MODE_SHIFT_OUT  = 3'd3;
    localparam logic [2:0] MODE_SAMPLE     = 3'd4;

    // Bit of the address byte that selects a master read.
    localparam int ADDR_RW_BIT = 0;

    // Command to one ring for the current transfer.
    typedef struct packed {
        logic push;
        logic pop;
        logic flush;
    } ring_cmd_t;

    // Status of one ring.
    typedef struct packed {
        logic full;
        logic empty;
        logic not_empty_next;
    } ring_stat_t;

    // Decisions of the sequencer for the current transfer.
    typedef struct packed {
        ring_cmd_t  rx_cmd;
        ring_cmd_t  tx_cmd;
        logic [2:0] mode;
        logic       refused;
        logic       overflow;
    } seq_ctl_t;

endpackage

`default_nettype wire

[rtl/core/i2csbc_ring.sv]
`default_nettype none

module i2csbc_ring
    import i2csbc_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire ring_cmd_t  cmd,
    input  wire logic [7:0] wdata,
    output ring_stat_t      stat,
    output logic [7:0]      rdata
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [7:0]    mem [DEPTH];
    logic [IW-1:0] wr_idx_reg, wr_idx_next;
    logic [IW-1:0] rd_idx_reg, rd_idx_next;
    logic [CW-1:0] count_reg, count_next;
    logic [7:0]    rdata_reg;

    // Occupancy flags from the current count; not_empty_next from the next count.
    assign stat.full  = (count_reg == CW'(DEPTH));
    assign stat.empty = (count_reg == '0);
    assign stat.not_empty_next = (count_next != '0);
    assign rdata = rdata_reg;

    // Index and count updates; the sequencer never pushes when full or pops when empty.
    always_comb begin
        wr_idx_next = wr_idx_reg;
        rd_idx_next = rd_idx_reg;
        count_next  = count_reg;
        if (cmd.flush) begin
            wr_idx_next = '0;
            rd_idx_next = '0;
            count_next  = '0;
        end else if (cmd.push) begin
            wr_idx_next = (wr_idx_reg == IW'(DEPTH - 1)) ? '0 : wr_idx_reg + 1'b1;
            count_next  = count_reg + 1'b1;
        end else if (cmd.pop) begin
            rd_idx_next = (rd_idx_reg == IW'(DEPTH - 1)) ? '0 : rd_idx_reg + 1'b1;
            count_next  = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_idx_reg <= '0;
            rd_idx_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_idx_reg <= wr_idx_next;
            rd_idx_reg <= rd_idx_next;
            count_reg  <= count_next;
        end
    end

    // Ring storage with a registered read port.
    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            mem[wr_idx_reg] <= wdata;
        end
        if (cmd.pop) begin
            rdata_reg <= mem[rd_idx_reg];
        end
    end

endmodule

`default_nettype wire

[rtl/core/i2csbc_seq.sv]
`default_nettype none

module i2csbc_seq
    import i2csbc_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       accept,
    input  wire logic [2:0] action,
    input  wire logic [7:0] bus_byte,
    input  wire logic [6:0] own_address,
    input  wire ring_stat_t rx_stat,
    input  wire ring_stat_t tx_stat,
    output seq_ctl_t        ctl
);

    typedef enum logic [6:0] {
        PH_WAIT_START  = 7'b0000001,
        PH_CHECK_ADDR  = 7'b0000010,
        PH_ACK_READ    = 7'b0000100,
        PH_SENDING     = 7'b0001000,
        PH_CHECK_REPLY = 7'b0010000,
        PH_ACK_WRITE   = 7'b0100000,
        PH_RECEIVING   = 7'b1000000
    } phase_t;

    phase_t phase_reg, phase_next;
    logic   addr_match;

    assign addr_match = (bus_byte == 8'd0) || (bus_byte[7:1] == own_address);

    // Phase and ring decisions for one accepted transfer.
    always_comb begin
        phase_next = phase_reg;
        ctl        = '0;
        if (accept) begin
            case (action)
                ACT_START: begin
                    phase_next = PH_CHECK_ADDR;
                end
                ACT_SHIFT: begin
                    case (phase_reg)
                        PH_CHECK_ADDR: begin
                            if (!addr_match) begin
                                phase_next = PH_WAIT_START;
                            end else if (bus_byte[ADDR_RW_BIT]) begin
                                phase_next = PH_ACK_READ;
                            end else begin
                                phase_next = PH_ACK_WRITE;
                            end
                        end
                        PH_ACK_READ, PH_CHECK_REPLY: begin
                            // A master NACK or an empty transmit ring ends the read; else the next byte is loaded.
                            if (phase_reg == PH_CHECK_REPLY && bus_byte != 8'd0) begin
                                phase_next = PH_WAIT_START;
                            end else if (!tx_stat.empty) begin
                                ctl.tx_cmd.pop = 1'b1;
                                phase_next     = PH_SENDING;
                            end else begin
                                phase_next = PH_WAIT_START;
                            end
                        end
                        PH_SENDING: begin
                            phase_next = PH_CHECK_REPLY;
                        end
                        PH_ACK_WRITE: begin
                            phase_next = PH_RECEIVING;
                        end
                        PH_RECEIVING: begin
                            if (!rx_stat.full) begin
                                ctl.rx_cmd.push = 1'b1;
                            end else begin
                                ctl.overflow = 1'b1;
                            end
                            phase_next = PH_ACK_WRITE;
                        end
                        default: begin
                            phase_next = phase_reg;
                        end
                    endcase
                end
                ACT_PUSH: begin
                    if (!tx_stat.full) begin
                        ctl.tx_cmd.push = 1'b1;
                    end else begin
                        ctl.refused = 1'b1;
                    end
                end
                ACT_POP: begin
                    ctl.rx_cmd.pop = !rx_stat.empty;
                end
                ACT_FLUSH: begin
                    ctl.rx_cmd.flush = 1'b1;
                    ctl.tx_cmd.flush = 1'b1;
                end
                default: begin
                    phase_next = phase_reg;
                end
            endcase
        end

        // Bus mode after the event.
        case (phase_next)
            PH_CHECK_ADDR:  ctl.mode = MODE_SAMPLE;
            PH_ACK_READ:    ctl.mode = MODE_DRIVE_ACK;
            PH_SENDING:     ctl.mode = MODE_SHIFT_OUT;
            PH_CHECK_REPLY: ctl.mode = MODE_SAMPLE_ACK;
            PH_ACK_WRITE:   ctl.mode = MODE_DRIVE_ACK;
            PH_RECEIVING:   ctl.mode = MODE_SAMPLE;
            default:        ctl.mode = MODE_WAIT_START;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_CHECK_ADDR;
        end else begin
            phase_reg <= phase_next;
        end
    end

endmodule

`default_nettype wire

[rtl/core/i2c_slave_byte_controller_core.sv]
// Byte-level I2C slave sequencer with a receive ring and a transmit ring. Each input
// transfer is one event (tuser: start condition, shift done, host push, host pop, flush)
// and yields exactly one result transfer with the bus mode, the byte to shift out, a
// popped byte and status flags. An event is accepted in any cycle in which the result
// register is empty or its result is taken at the same edge, so events can follow back
// to back at one per clock cycle. The result is presented in the cycle after acceptance,
// since the ring memories read the popped entry at the accepting edge. While a result
// waits for m_tready, s_tready stays low. Configuration writes of own_address are taken
// at any time but are meant to happen only while the block is idle. Ring depths are set
// by RX_DEPTH and TX_DEPTH.
`default_nettype none

module i2c_slave_byte_controller_core
    import i2csbc_pkg::*;
#(
    parameter int RX_DEPTH = 16,
    parameter int TX_DEPTH = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [6:0]  cfg_data,     // own_address[6:0]
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,      // bus_byte[7:0], host_byte[15:8]
    input  wire logic [2:0]  s_tuser,      // action[2:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata       // bus_mode[2:0], send_byte[10:3],
                                           // host_data[18:11], host_data_valid[19],
                                           // rx_not_empty[20], push_refused[21],
                                           // rx_overflow[22], zero[23]
);

    logic [6:0] own_addr_reg;
    logic       accept;
    seq_ctl_t   ctl;
    ring_stat_t rx_stat, tx_stat;
    logic [7:0] rx_rdata, tx_rdata;

    logic       out_valid_reg;
    logic [2:0] mode_reg;
    logic       hvalid_reg;
    logic       not_empty_reg;
    logic       refused_reg;
    logic       overflow_reg;
    logic       load_reg;
    logic [7:0] shift_out_reg;
    logic [7:0] shift_cur;
    logic [7:0] send_byte;
    logic [7:0] host_data;

    // Configuration register.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_addr_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            own_addr_reg <= cfg_data;
        end
    end

    // A new event enters whenever the output register is free or being emptied.
    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    i2csbc_seq u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .action      (s_tuser),
        .bus_byte    (s_tdata[7:0]),
        .own_address (own_addr_reg),
        .rx_stat     (rx_stat),
        .tx_stat     (tx_stat),
        .ctl         (ctl)
    );

    i2csbc_ring #(
        .DEPTH (RX_DEPTH)
    ) u_rx_ring (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (ctl.rx_cmd),
        .wdata   (s_tdata[7:0]),
        .stat    (rx_stat),
        .rdata   (rx_rdata)
    );

    i2csbc_ring #(
        .DEPTH (TX_DEPTH)
    ) u_tx_ring (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (ctl.tx_cmd),
        .wdata   (s_tdata[15:8]),
        .stat    (tx_stat),
        .rdata   (tx_rdata)
    );

    // The byte being sent is the freshly read ring entry right after a load.
    assign shift_cur = load_reg ? tx_rdata : shift_out_reg;

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            load_reg      <= 1'b0;
            shift_out_reg <= '0;
        end else begin
            if (accept) begin
                out_valid_reg <= 1'b1;
                load_reg      <= ctl.tx_cmd.pop;
                shift_out_reg <= shift_cur;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            mode_reg      <= ctl.mode;
            hvalid_reg    <= ctl.rx_cmd.pop;
            not_empty_reg <= rx_stat.not_empty_next;
            refused_reg   <= ctl.refused;
            overflow_reg  <= ctl.overflow;
        end
    end

    // Unused payload fields read as zero.
    assign send_byte = (mode_reg == MODE_SHIFT_OUT) ? shift_cur : 8'd0;
    assign host_data = hvalid_reg ? rx_rdata : 8'd0;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, overflow_reg, refused_reg, not_empty_reg, hvalid_reg,
                       host_data, send_byte, mode_reg};

endmodule

`default_nettype wire

[dv/i2c_slave_byte_controller_core_test.sv]
`default_nettype none

module i2c_slave_byte_controller_core_test
    import i2csbc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RX_RING_DEPTH = 16;
    localparam int TX_RING_DEPTH = 16;
    localparam int STALL_PERCENT = 31;
    localparam int WATCHDOG_LIMIT = 4000;

    // Event codes the block does not define; they must leave all state alone.
    localparam logic [2:0] ACT_RSVD_LO = 3'd5;
    localparam logic [2:0] ACT_RSVD_HI = 3'd7;

    // Address byte of a general call.
    localparam logic [7:0] GENERAL_CALL = 8'h00;

    // Sequencer phases as tracked by the predictor.
    typedef enum logic [2:0] {
        SQ_IDLE,
        SQ_ADDRESS,
        SQ_READ_ACK,
        SQ_TX_BYTE,
        SQ_TX_REPLY,
        SQ_WRITE_ACK,
        SQ_RX_BYTE
    } seq_phase_t;

    // Result word as laid out on m_tdata, top bit first.
    typedef struct packed {
        logic       pad;
        logic       rx_overflow;
        logic       push_refused;
        logic       rx_not_empty;
        logic       host_data_valid;
        logic [7:0] host_data;
        logic [7:0] send_byte;
        logic [2:0] bus_mode;
    } bus_status_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [6:0]  cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic [2:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;

    // Predictor state: sequencer phase, address and both rings.
    seq_phase_t  seq_phase = SQ_ADDRESS;
    logic [6:0]  own_addr = 7'd0;
    logic [7:0]  rx_mem [RX_RING_DEPTH];
    logic [7:0]  tx_mem [TX_RING_DEPTH];
    logic [3:0]  rx_wr = '0;
    logic [3:0]  rx_rd = '0;
    logic [3:0]  tx_wr = '0;
    logic [3:0]  tx_rd = '0;
    int          rx_fill = 0;
    int          tx_fill = 0;
    logic [7:0]  tx_shift = '0;

    bus_status_t expected_status_q[$];
    int          error_count = 0;
    int          sent_items = 0;
    int          idle_cycles = 0;
    logic        steady_flow = 1'b0;

    i2c_slave_byte_controller_core #(
        .RX_DEPTH (RX_RING_DEPTH),
        .TX_DEPTH (TX_RING_DEPTH)
    ) u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // Clock with a 12 ns period.
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // The result side stalls at random unless a steady stretch is running.
    always @(posedge aclk) begin
        m_tready <= steady_flow || ($urandom_range(99) >= STALL_PERCENT);
    end

    // Load the next transmit byte, or give up the read when the ring is empty.
    function automatic void fetch_tx_byte();
        if (tx_fill != 0) begin
            tx_shift = tx_mem[tx_rd];
            tx_rd++;
            tx_fill--;
            seq_phase = SQ_TX_BYTE;
        end else begin
            seq_phase = SQ_IDLE;
        end
    endfunction

    // Advance the sequencer and rings by one event and return its status word.
    function automatic bus_status_t advance_sequencer(input logic [2:0] act,
                                                      input logic [7:0] bus_byte,
                                                      input logic [7:0] host_byte);
        bus_status_t st;
        st = '0;
        case (act)
            ACT_START: seq_phase = SQ_ADDRESS;
            ACT_SHIFT: begin
                case (seq_phase)
                    SQ_ADDRESS: begin
                        if (bus_byte == GENERAL_CALL || bus_byte[7:1] == own_addr)
                            seq_phase = bus_byte[ADDR_RW_BIT] ? SQ_READ_ACK : SQ_WRITE_ACK;
                        else
                            seq_phase = SQ_IDLE;
                    end
                    SQ_READ_ACK:  fetch_tx_byte();
                    SQ_TX_BYTE:   seq_phase = SQ_TX_REPLY;
                    SQ_TX_REPLY: begin
                        // Any nonzero sample is a NACK from the master.
                        if (bus_byte != 8'h00)
                            seq_phase = SQ_IDLE;
                        else
                            fetch_tx_byte();
                    end
                    SQ_WRITE_ACK: seq_phase = SQ_RX_BYTE;
                    SQ_RX_BYTE: begin
                        if (rx_fill < RX_RING_DEPTH) begin
                            rx_mem[rx_wr] = bus_byte;
                            rx_wr++;
                            rx_fill++;
                        end else begin
                            st.rx_overflow = 1'b1;
                        end
                        seq_phase = SQ_WRITE_ACK;
                    end
                    default: ;
                endcase
            end
            ACT_PUSH: begin
                if (tx_fill < TX_RING_DEPTH) begin
                    tx_mem[tx_wr] = host_byte;
                    tx_wr++;
                    tx_fill++;
                end else begin
                    st.push_refused = 1'b1;
                end
            end
            ACT_POP: begin
                if (rx_fill != 0) begin
                    st.host_data = rx_mem[rx_rd];
                    st.host_data_valid = 1'b1;
                    rx_rd++;
                    rx_fill--;
                end
            end
            ACT_FLUSH: begin
                rx_wr = '0;
                rx_rd = '0;
                tx_wr = '0;
                tx_rd = '0;
                rx_fill = 0;
                tx_fill = 0;
            end
            default: ;
        endcase

        case (seq_phase)
            SQ_ADDRESS, SQ_RX_BYTE:     st.bus_mode = MODE_SAMPLE;
            SQ_READ_ACK, SQ_WRITE_ACK:  st.bus_mode = MODE_DRIVE_ACK;
            SQ_TX_BYTE:                 st.bus_mode = MODE_SHIFT_OUT;
            SQ_TX_REPLY:                st.bus_mode = MODE_SAMPLE_ACK;
            default:                    st.bus_mode = MODE_WAIT_START;
        endcase
        if (st.bus_mode == MODE_SHIFT_OUT)
            st.send_byte = tx_shift;
        st.rx_not_empty = (rx_fill != 0);
        return st;
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
            error_count++;
        end
    endfunction

    // Compare every result transfer with the oldest predicted status.
    always @(posedge aclk) begin
        bus_status_t got;
        bus_status_t want;
        if (aresetn === 1'b1 && m_tvalid && m_tready) begin
            got = m_tdata;
            if (expected_status_q.size() == 0) begin
                $error("result transfer 0x%06h arrived with nothing predicted", m_tdata);
                error_count++;
            end else begin
                want = expected_status_q.pop_front();
                check_field("bus_mode", want.bus_mode, got.bus_mode);
                check_field("send_byte", want.send_byte, got.send_byte);
                check_field("host_data", want.host_data, got.host_data);
                check_field("host_data_valid", want.host_data_valid, got.host_data_valid);
                check_field("rx_not_empty", want.rx_not_empty, got.rx_not_empty);
                check_field("push_refused", want.push_refused, got.push_refused);
                check_field("rx_overflow", want.rx_overflow, got.rx_overflow);
                check_field("pad", want.pad, got.pad);
            end
        end
    end

    // Watchdog: end the run when no transfer of any kind happens for too long.
    always @(posedge aclk) begin
        if (aresetn !== 1'b1 || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic logic [7:0] rand_byte();
        return 8'($urandom);
    endfunction

    // Offer one event, with random gaps, and predict its result once it is taken.
    task automatic send_event(input logic [2:0] act, input logic [7:0] bus_byte,
                              input logic [7:0] host_byte);
        if (!steady_flow) begin
            while ($urandom_range(99) < STALL_PERCENT) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {host_byte, bus_byte};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_status_q.push_back(advance_sequencer(act, bus_byte, host_byte));
        sent_items++;
    endtask

    // Stop sending and wait until every predicted result has come back.
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (expected_status_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_own_address(input logic [6:0] addr);
        cfg_valid <= 1'b1;
        cfg_data  <= addr;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        own_addr = addr;
    endtask

    // Address byte for a transaction: mostly our own, sometimes a general call
    // (write only) or an arbitrary byte that will usually miss.
    function automatic logic [7:0] pick_address(input logic rw);
        int roll;
        roll = $urandom_range(99);
        if (roll < 70)
            return {own_addr, rw};
        else if (roll < 85 && !rw)
            return GENERAL_CALL;
        else
            return rand_byte();
    endfunction

    // Extremes of the fields and each special case, with the reset address of zero.
    task automatic test_directed();
        send_event(ACT_POP, rand_byte(), rand_byte());      // pop from empty ring
        send_event(ACT_PUSH, rand_byte(), 8'hFF);
        send_event(ACT_PUSH, rand_byte(), 8'h00);
        send_event(ACT_SHIFT, 8'hFE, rand_byte());          // address mismatch
        send_event(ACT_SHIFT, 8'h55, rand_byte());          // shift while waiting
        // Master read of both bytes, ended by a NACK.
        send_event(ACT_START, rand_byte(), rand_byte());
        send_event(ACT_SHIFT, 8'h01, rand_byte());
        send_event(ACT_SHIFT, rand_byte(), rand_byte());
        send_event(ACT_SHIFT, rand_byte(), rand_byte());
        send_event(ACT_SHIFT, 8'h00, rand_byte());
        send_event(ACT_SHIFT, rand_byte(), rand_byte());
        send_event(ACT_SHIFT, 8'h01, rand_byte());
        // Master read with an empty transmit ring.
        send_event(ACT_START, rand_byte(), rand_byte());
        send_event(ACT_SHIFT, 8'h01, rand_byte());
        send_event(ACT_SHIFT, rand_byte(), rand_byte());
        // General call write of two bytes.
        send_event(ACT_START, rand_byte(), rand_byte());
        send_event(ACT_SHIFT, GENERAL_CALL, rand_byte());
        send_event(ACT_SHIFT, rand_byte(), rand_byte());
        send_event(ACT_SHIFT, 8'hFF, rand_byte());
        send_event(ACT_SHIFT, rand_byte(), rand_byte());
        send_event(ACT_SHIFT, 8'h00, rand_byte());
        send_event(ACT_POP, rand_byte(), rand_byte());
        send_event(ACT_RSVD_LO, rand_byte(), rand_byte());
        send_event(ACT_RSVD_HI, rand_byte(), rand_byte());
        send_event(ACT_FLUSH, rand_byte(), rand_byte());
        send_event(ACT_POP, rand_byte(), rand_byte());
    endtask

    // Fill both rings past their depth, then drain the receive ring.
    task automatic test_full_rings();
        send_event(ACT_FLUSH, rand_byte(), rand_byte());
        repeat (TX_RING_DEPTH + 1) send_event(ACT_PUSH, rand_byte(), rand_byte());
        send_event(ACT_START, rand_byte(), rand_byte());
        send_event(ACT_SHIFT, {own_addr, 1'b0}, rand_byte());
        repeat (RX_RING_DEPTH + 1) begin
            send_event(ACT_SHIFT, rand_byte(), rand_byte());
            send_event(ACT_SHIFT, rand_byte(), rand_byte());
        end
        repeat (RX_RING_DEPTH + 1) send_event(ACT_POP, rand_byte(), rand_byte());
    endtask

    // Mostly well-formed read and write transactions with random content,
    // mixed with host accesses and random noise.
    task automatic run_random_traffic(input int n_items);
        int first_item;
        int roll;
        int n_bytes;
        first_item = sent_items;
        while (sent_items - first_item < n_items) begin
            roll = $urandom_range(99);
            if (roll < 35) begin
                send_event(ACT_START, rand_byte(), rand_byte());
                send_event(ACT_SHIFT, pick_address(1'b0), rand_byte());
                n_bytes = $urandom_range(6);
                repeat (n_bytes) begin
                    send_event(ACT_SHIFT, rand_byte(), rand_byte());
                    send_event(ACT_SHIFT, rand_byte(), rand_byte());
                end
            end else if (roll < 65) begin
                n_bytes = $urandom_range(4);
                repeat (n_bytes) send_event(ACT_PUSH, rand_byte(), rand_byte());
                send_event(ACT_START, rand_byte(), rand_byte());
                send_event(ACT_SHIFT, pick_address(1'b1), rand_byte());
                send_event(ACT_SHIFT, rand_byte(), rand_byte());
                n_bytes = $urandom_range(5);
                repeat (n_bytes) begin
                    send_event(ACT_SHIFT, rand_byte(), rand_byte());
                    // Mostly ACK; now and then a NACK with random bits set.
                    send_event(ACT_SHIFT, ($urandom_range(7) == 0) ? rand_byte() : 8'h00,
                               rand_byte());
                end
            end else if (roll < 85) begin
                n_bytes = $urandom_range(1, 4);
                repeat (n_bytes) send_event(ACT_POP, rand_byte(), rand_byte());
            end else if (roll < 88) begin
                send_event(ACT_FLUSH, rand_byte(), rand_byte());
            end else begin
                send_event(3'($urandom_range(ACT_RSVD_HI)), rand_byte(), rand_byte());
            end
        end
    endtask

    // Several address settings, the extremes among them, one run without stalls.
    task automatic test_random_traffic();
        logic [6:0] addr_list [6];
        addr_list = '{7'h7F, 7'h00, 7'($urandom), 7'h55, 7'($urandom), 7'($urandom)};
        foreach (addr_list[i]) begin
            wait_for_results();
            write_own_address(addr_list[i]);
            steady_flow = (i == 3);
            run_random_traffic(170);
            steady_flow = 1'b0;
        end
    endtask

    initial begin
        aresetn   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        s_tvalid  <= 1'b0;
        s_tuser   <= ACT_START;
        s_tdata   <= '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        wait_for_results();
        write_own_address(7'h7F);
        test_full_rings();
        test_random_traffic();
        wait_for_results();
        repeat (8) @(posedge aclk);

        if (error_count == 0 && expected_status_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
